/* rtl/core/pn3_pkg.sv */
// pn3_pkg: shared types and constants for the 3D Perlin noise evaluator.
// No dependencies.
`timescale 1ns / 1ps
package pn3_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_FADE_MUL,
    ST_FADE_ACC,
    ST_LERP_MUL,
    ST_LERP_ACC,
    ST_DONE
  } pn3_state_e;

  // Request operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // Gradient selection codes
  localparam logic [3:0] GRAD_A_Y_FROM = 4'd8;
  localparam logic [3:0] GRAD_B_Z_FROM = 4'd4;
  localparam logic [3:0] GRAD_B_X_LO   = 4'd12;
  localparam logic [3:0] GRAD_B_X_HI   = 4'd14;

  // Table read schedule
  localparam logic [3:0] RD_LAST = 4'd14;

  // Output range
  localparam int OUT_W   = 18;
  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN = -131072;

endpackage

/* rtl/core/perlin_noise_3d.sv */
// perlin_noise_3d: improved 3D Perlin noise, Q16.16 in, saturated Q2.16 out.
// Sequence: a table write completes while idle; an evaluation, once accepted, makes 14
// table reads through the registered read port, then 12 fade multiplies and 7 lerps as
// multiply and accumulate steps on one shared multiplier, then holds its result until taken.
// Throughput: writes back to back; an evaluation holds the block until its result is taken.
// Reset: rst_ni (async, low) clears the sequencer; the table is undefined until written.
// Depends on pn3_pkg, pn3_perm_mem, pn3_mul.
`timescale 1ns / 1ps
module perlin_noise_3d #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [31:0] coord_x_i,
  input  logic [31:0] coord_y_i,
  input  logic [31:0] coord_z_i,
  input  logic [7:0]  table_index_i,
  input  logic [7:0]  table_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [pn3_pkg::OUT_W-1:0] noise_value_o
);

  import pn3_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int AW = F + 5;          // multiplier signed operand
  localparam int BW = F + 1;          // multiplier unsigned operand
  localparam int PW = AW + BW + 1;    // product
  localparam int GW = F + 3;          // gradient
  localparam int VW = F + 4;          // lerp values
  localparam int MW = F + 4;          // fade intermediate
  localparam int SW = (VW > OUT_W) ? VW : OUT_W;

  localparam logic [BW-1:0] ONE_B   = BW'(1) << F;
  localparam logic [PW-1:0] HALF_P  = PW'(1) << (F - 1);
  localparam logic [PW-1:0] TEN_SQ  = PW'(10) << (2 * F);
  localparam logic [AW-1:0] FIFT_S  = AW'(15) << F;

  pn3_state_e state_q, state_d;

  logic [3:0]   rd_cnt_q;
  logic [1:0]   axis_q;
  logic [1:0]   iter_q;
  logic [2:0]   lerp_q;
  logic [F-1:0] fx_q, fy_q, fz_q;
  logic [7:0]   ix_q, iy_q, iz_q;
  logic [7:0]   a_q, b_q, aa_q, ab_q, ba_q, bb_q;
  logic [3:0]   hash_q [8];
  logic [MW-1:0] m_q;
  logic [BW-1:0] fade_q [3];
  logic signed [VW-1:0] res_q [4];
  logic signed [OUT_W-1:0] noise_q;

  logic        in_acc;
  logic [7:0]  rd_addr;
  logic [7:0]  rd_data;
  logic [3:0]  rd_idx;
  logic [2:0]  hk;

  logic signed [AW-1:0] mul_a;
  logic        [BW-1:0] mul_b;
  logic signed [PW-1:0] prod;

  logic [F-1:0]         t_sel;
  logic signed [PW-1:0] fade_sum;
  logic [MW-1:0]        m_new;

  logic signed [GW-1:0] ox0, ox1, oy, oz;
  logic signed [GW-1:0] g_lo, g_hi;
  logic signed [VW-1:0] op_a, op_b, diff, lerp_res;
  logic        [BW-1:0] op_w;
  logic signed [PW-1:0] lerp_rnd;
  logic signed [SW-1:0] res_ext;

  // Gradient: signed sum of two corner offsets picked by the hash
  function automatic logic signed [GW-1:0] grad(
    input logic [3:0] h,
    input logic signed [GW-1:0] x,
    input logic signed [GW-1:0] y,
    input logic signed [GW-1:0] z
  );
    logic signed [GW-1:0] a;
    logic signed [GW-1:0] b;
    a = (h < GRAD_A_Y_FROM) ? x : y;
    if (h < GRAD_B_Z_FROM) begin
      b = y;
    end else if (h == GRAD_B_X_LO || h == GRAD_B_X_HI) begin
      b = x;
    end else begin
      b = z;
    end
    return (h[0] ? -a : a) + (h[1] ? -b : b);
  endfunction

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_DONE);
  assign in_acc      = in_valid_i & in_ready_o;
  assign noise_value_o = noise_q;

  // Permutation table
  pn3_perm_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (in_acc && (operation_i == OP_WRITE)),
    .waddr_i (table_index_i),
    .wdata_i (table_value_i),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Shared multiplier
  pn3_mul #(.AW(AW), .BW(BW)) u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Table read address schedule
  always_comb begin
    case (rd_cnt_q)
      4'd0:    rd_addr = ix_q;
      4'd1:    rd_addr = ix_q + 8'd1;
      4'd2:    rd_addr = a_q;
      4'd3:    rd_addr = a_q + 8'd1;
      4'd4:    rd_addr = b_q;
      4'd5:    rd_addr = b_q + 8'd1;
      4'd6:    rd_addr = aa_q;
      4'd7:    rd_addr = aa_q + 8'd1;
      4'd8:    rd_addr = ab_q;
      4'd9:    rd_addr = ab_q + 8'd1;
      4'd10:   rd_addr = ba_q;
      4'd11:   rd_addr = ba_q + 8'd1;
      4'd12:   rd_addr = bb_q;
      4'd13:   rd_addr = bb_q + 8'd1;
      default: rd_addr = ix_q;
    endcase
  end

  assign rd_idx = rd_cnt_q - 4'd1;
  assign hk     = 3'(rd_idx - 4'd6);

  // Fade datapath
  always_comb begin
    case (axis_q)
      2'd0:    t_sel = fx_q;
      2'd1:    t_sel = fy_q;
      default: t_sel = fz_q;
    endcase
    fade_sum = prod + $signed(HALF_P) + ((iter_q == 2'd0) ? $signed(TEN_SQ) : '0);
    m_new    = fade_sum[F +: MW];
  end

  // Lerp operand selection
  always_comb begin
    ox0  = GW'(fx_q);
    ox1  = GW'(fx_q) - GW'(ONE_B);
    oy   = lerp_q[0] ? (GW'(fy_q) - GW'(ONE_B)) : GW'(fy_q);
    oz   = lerp_q[1] ? (GW'(fz_q) - GW'(ONE_B)) : GW'(fz_q);
    g_lo = grad(hash_q[0], ox0, oy, oz);
    g_hi = grad(hash_q[1], ox1, oy, oz);
    case (lerp_q)
      3'd4: begin
        op_a = res_q[0];
        op_b = res_q[1];
        op_w = fade_q[1];
      end
      3'd5: begin
        op_a = res_q[1];
        op_b = res_q[2];
        op_w = fade_q[1];
      end
      3'd6: begin
        op_a = res_q[2];
        op_b = res_q[3];
        op_w = fade_q[2];
      end
      default: begin
        op_a = {{(VW-GW){g_lo[GW-1]}}, g_lo};
        op_b = {{(VW-GW){g_hi[GW-1]}}, g_hi};
        op_w = fade_q[0];
      end
    endcase
    diff     = op_b - op_a;
    lerp_rnd = prod + $signed(HALF_P);
    lerp_res = op_a + $signed(lerp_rnd[F +: VW]);
    res_ext  = {{(SW-VW){lerp_res[VW-1]}}, lerp_res};
  end

  // Multiplier operands
  always_comb begin
    if (state_q == ST_LERP_MUL) begin
      mul_a = {diff[VW-1], diff};
      mul_b = op_w;
    end else if (iter_q == 2'd0) begin
      mul_a = $signed(AW'(t_sel) * AW'(6)) - $signed(FIFT_S);
      mul_b = BW'(t_sel);
    end else begin
      mul_a = AW'(m_q);
      mul_b = BW'(t_sel);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (operation_i == OP_EVAL)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (rd_cnt_q == RD_LAST) begin
          state_d = ST_FADE_MUL;
        end
      end
      ST_FADE_MUL: state_d = ST_FADE_ACC;
      ST_FADE_ACC: begin
        if (iter_q == 2'd3 && axis_q == 2'd2) begin
          state_d = ST_LERP_MUL;
        end else begin
          state_d = ST_FADE_MUL;
        end
      end
      ST_LERP_MUL: state_d = ST_LERP_ACC;
      ST_LERP_ACC: begin
        if (lerp_q == 3'd6) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_LERP_MUL;
        end
      end
      ST_DONE: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_cnt_q <= '0;
      axis_q   <= '0;
      iter_q   <= '0;
      lerp_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE) begin
        rd_cnt_q <= '0;
        axis_q   <= '0;
        iter_q   <= '0;
        lerp_q   <= '0;
      end
      if (state_q == ST_READ) begin
        rd_cnt_q <= rd_cnt_q + 4'd1;
      end
      if (state_q == ST_FADE_ACC) begin
        iter_q <= iter_q + 2'd1;
        if (iter_q == 2'd3) begin
          axis_q <= axis_q + 2'd1;
        end
      end
      if (state_q == ST_LERP_ACC) begin
        lerp_q <= lerp_q + 3'd1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc && (operation_i == OP_EVAL)) begin
      fx_q <= coord_x_i[F-1:0];
      fy_q <= coord_y_i[F-1:0];
      fz_q <= coord_z_i[F-1:0];
      ix_q <= coord_x_i[F +: 8];
      iy_q <= coord_y_i[F +: 8];
      iz_q <= coord_z_i[F +: 8];
    end
    // capture hashes from the previous read
    if (state_q == ST_READ && rd_cnt_q != 4'd0) begin
      case (rd_idx)
        4'd0:    a_q  <= rd_data + iy_q;
        4'd1:    b_q  <= rd_data + iy_q;
        4'd2:    aa_q <= rd_data + iz_q;
        4'd3:    ab_q <= rd_data + iz_q;
        4'd4:    ba_q <= rd_data + iz_q;
        4'd5:    bb_q <= rd_data + iz_q;
        default: hash_q[{hk[0], hk[1], hk[2]}] <= rd_data[3:0];
      endcase
    end
    // fade iteration
    if (state_q == ST_FADE_ACC) begin
      m_q <= m_new;
      if (iter_q == 2'd3) begin
        fade_q[axis_q] <= (m_new > MW'(ONE_B)) ? ONE_B : BW'(m_new);
      end
    end
    // lerp result shifts in at the top
    if (state_q == ST_LERP_ACC) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
      res_q[2] <= res_q[3];
      res_q[3] <= lerp_res;
      if (lerp_q < 3'd4) begin
        for (int n = 0; n < 6; n++) begin
          hash_q[n] <= hash_q[n+2];
        end
      end
      if (lerp_q == 3'd6) begin
        if (res_ext > $signed(SW'(OUT_MAX))) begin
          noise_q <= OUT_W'(OUT_MAX);
        end else if (res_ext < $signed(SW'(OUT_MIN))) begin
          noise_q <= OUT_W'(OUT_MIN);
        end else begin
          noise_q <= res_ext[OUT_W-1:0];
        end
      end
    end
  end

`ifndef SYNTH
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("ready and result valid at once");
  a_eval_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && operation_i == OP_EVAL) |=> (state_q == ST_READ && rd_cnt_q == 4'd0))
    else $error("evaluation did not start reading");
  a_write_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && operation_i == OP_WRITE) |=> (state_q == ST_IDLE))
    else $error("table write left idle");
  a_rd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (rd_cnt_q <= RD_LAST))
    else $error("read counter overrun");
  a_lerp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LERP_MUL || state_q == ST_LERP_ACC) |-> (lerp_q <= 3'd6))
    else $error("lerp counter overrun");
`endif

endmodule

/* rtl/core/pn3_perm_mem.sv */
// pn3_perm_mem: 256 x 8 permutation table, one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module pn3_perm_mem (
  input  logic       clk_i,
  input  logic       we_i,
  input  logic [7:0] waddr_i,
  input  logic [7:0] wdata_i,
  input  logic [7:0] raddr_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem_q [256];
  logic [7:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/pn3_mul.sv */
// pn3_mul: shared signed x unsigned multiplier with registered product.
// No dependencies.
`timescale 1ns / 1ps
module pn3_mul #(
  parameter int AW = 21,
  parameter int BW = 17
) (
  input  logic                     clk_i,
  input  logic signed [AW-1:0]     a_i,
  input  logic        [BW-1:0]     b_i,
  output logic signed [AW+BW:0]    prod_o
);

  logic signed [AW+BW:0] prod_q;

  // One product per cycle, result next cycle
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * $signed({1'b0, b_i});
  end

  assign prod_o = prod_q;

endmodule
